/* rtl/positional_insert_delete_array_core_macros.svh */
// Assertion macros for the positional insert/delete array core.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_CORE_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define PIDA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PIDA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pida_pkg.sv */
// Package for the positional insert/delete array core: widths, codes, defaults.
// No dependencies.
`default_nettype none

package pida_pkg;

  localparam int unsigned PidaCapacity = 64;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned ValW  = 32;
  localparam int unsigned PosW  = 7;
  localparam int unsigned StatW = 2;
  localparam int unsigned IdxW  = 6;

  typedef enum logic [CmdW-1:0] {
    CMD_READ_ALL = 2'd0,
    CMD_INSERT   = 2'd1,
    CMD_DELETE   = 2'd2
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

endpackage

`default_nettype wire

/* rtl/pida_in_if.sv */
// Command channel of the positional insert/delete array core.
// Depends on pida_pkg.
`default_nettype none

interface pida_in_if;
  logic                             valid;
  logic                             ready;
  logic [pida_pkg::CmdW-1:0]        cmd;
  logic signed [pida_pkg::ValW-1:0] value;
  logic [pida_pkg::PosW-1:0]        position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

`default_nettype wire

/* rtl/pida_out_if.sv */
// Result channel of the positional insert/delete array core.
// Depends on pida_pkg.
`default_nettype none

interface pida_out_if;
  logic                             valid;
  logic                             ready;
  logic [pida_pkg::StatW-1:0]       status;
  logic [pida_pkg::IdxW-1:0]        entry_index;
  logic signed [pida_pkg::ValW-1:0] entry_value;
  logic                             last;

  modport source (output valid, output status, output entry_index, output entry_value,
                  output last, input ready);
  modport sink   (input valid, input status, input entry_index, input entry_value,
                  input last, output ready);
endinterface

`default_nettype wire

/* rtl/positional_insert_delete_array_core.sv */
// Top level of the positional insert/delete array core: sequencer, entry memory, result register.
// Depends on pida_pkg, pida_in_if, pida_out_if and the assertion macro header.
`default_nettype none
`include "positional_insert_delete_array_core_macros.svh"

// Holds a packed list of up to Capacity signed words in a single-port-write,
// registered-read memory, plus a count. One command is taken at a time; ready
// is high only while the sequencer is idle. Insert and delete move the entries
// above the position one per cycle through the memory (read, then write one
// slot up or down); every edit ends in one status beat, after any wait on the
// result channel. Read all emits one beat per entry (memory read, then load
// of the result register once it is free) with last on the final entry, or a
// single empty status beat. Command code 3 is dropped without a beat. Entry
// storage has no reset; only the count and control are cleared.
module positional_insert_delete_array_core #(
  parameter int unsigned Capacity = pida_pkg::PidaCapacity
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  pida_in_if.sink   in_i,
  pida_out_if.source out_o
);
  import pida_pkg::*;

  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW  = $clog2(Capacity + 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SHIFT   = 7'b0000010,
    S_DRAIN   = 7'b0000100,
    S_WRITE   = 7'b0001000,
    S_RD_REQ  = 7'b0010000,
    S_RD_WAIT = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0]  end_q, end_d;
  logic [AddrW-1:0]  ins_addr_q, ins_addr_d;
  logic              up_q, up_d;
  logic signed [ValW-1:0] val_q, val_d;
  status_e           status_q, status_d;

  logic              pend_q;
  logic [AddrW-1:0]  wa_q, wa_d;

  logic [ValW-1:0]   mem [Capacity];
  logic [ValW-1:0]   rd_data_q;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic              we;
  logic [AddrW-1:0]  wr_addr;
  logic [ValW-1:0]   wr_data;

  logic              out_vld_q, out_vld_d;
  status_e           out_stat_q, out_stat_d;
  logic [IdxW-1:0]   out_idx_q, out_idx_d;
  logic [ValW-1:0]   out_val_q, out_val_d;
  logic              out_last_q, out_last_d;
  logic              out_load;
  logic              out_free;

  logic              in_fire;
  logic [7:0]        cnt8;
  logic [7:0]        pos8;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign cnt8     = 8'(count_q);
  assign pos8     = 8'(in_i.position);

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_vld_q;
  assign out_o.status      = out_stat_q;
  assign out_o.entry_index = out_idx_q;
  assign out_o.entry_value = out_val_q;
  assign out_o.last        = out_last_q;

  // pending shift write lands in the cycle after its read
  assign we      = pend_q || (state_q == S_WRITE);
  assign wr_addr = pend_q ? wa_q : ins_addr_q;
  assign wr_data = pend_q ? rd_data_q : val_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    end_d      = end_q;
    ins_addr_d = ins_addr_q;
    up_d       = up_q;
    val_d      = val_q;
    status_d   = status_q;
    rd_en      = 1'b0;
    rd_addr    = idx_q;
    wa_d       = up_q ? idx_q + AddrW'(1) : idx_q - AddrW'(1);
    out_load   = 1'b0;
    out_stat_d = out_stat_q;
    out_idx_d  = out_idx_q;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          val_d = in_i.value;
          unique case (cmd_e'(in_i.cmd))
            CMD_READ_ALL: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
                state_d  = S_RESP;
              end else begin
                idx_d   = '0;
                end_d   = AddrW'(cnt8 - 8'd1);
                state_d = S_RD_REQ;
              end
            end
            CMD_INSERT: begin
              if (count_q == CntW'(Capacity)) begin
                status_d = STAT_FULL;
                state_d  = S_RESP;
              end else if (pos8 == 8'd0 || pos8 > cnt8 + 8'd1) begin
                status_d = STAT_BADPOS;
                state_d  = S_RESP;
              end else begin
                status_d   = STAT_OK;
                count_d    = count_q + CntW'(1);
                ins_addr_d = AddrW'(pos8 - 8'd1);
                up_d       = 1'b1;
                if (pos8 == cnt8 + 8'd1) begin
                  state_d = S_WRITE;
                end else begin
                  idx_d   = AddrW'(cnt8 - 8'd1);
                  end_d   = AddrW'(pos8 - 8'd1);
                  state_d = S_SHIFT;
                end
              end
            end
            CMD_DELETE: begin
              if (pos8 == 8'd0 || pos8 > cnt8) begin
                status_d = STAT_BADPOS;
                state_d  = S_RESP;
              end else begin
                status_d = STAT_OK;
                count_d  = count_q - CntW'(1);
                up_d     = 1'b0;
                if (pos8 == cnt8) begin
                  state_d = S_RESP;
                end else begin
                  idx_d   = AddrW'(pos8);
                  end_d   = AddrW'(cnt8 - 8'd1);
                  state_d = S_SHIFT;
                end
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SHIFT: begin
        rd_en = 1'b1;
        if (idx_q == end_q) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = up_q ? idx_q - AddrW'(1) : idx_q + AddrW'(1);
        end
      end
      S_DRAIN: begin
        state_d = up_q ? S_WRITE : S_RESP;
      end
      S_WRITE: begin
        state_d = S_RESP;
      end
      S_RD_REQ: begin
        if (out_free) begin
          rd_en   = 1'b1;
          state_d = S_RD_WAIT;
        end
      end
      S_RD_WAIT: begin
        out_load   = 1'b1;
        out_stat_d = STAT_OK;
        out_idx_d  = IdxW'(idx_q);
        out_val_d  = rd_data_q;
        out_last_d = (idx_q == end_q);
        if (idx_q == end_q) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + AddrW'(1);
          state_d = S_RD_REQ;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_stat_d = status_q;
          out_idx_d  = '0;
          out_val_d  = '0;
          out_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= rd_en && (state_q == S_SHIFT);
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    end_q      <= end_d;
    ins_addr_q <= ins_addr_d;
    up_q       <= up_d;
    val_q      <= val_d;
    status_q   <= status_d;
    wa_q       <= wa_d;
    out_stat_q <= out_stat_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  `PIDA_ASSERT_ALWAYS(a_count_bound, clk_i, count_q <= CntW'(Capacity), "count above capacity")
  `PIDA_ASSERT(a_pend_in_shift, clk_i, rst_ni, pend_q |-> (state_q == S_SHIFT || state_q == S_DRAIN), "shift write outside shift")
  `PIDA_ASSERT(a_rd_slot_free, clk_i, rst_ni, (state_q == S_RD_WAIT) |-> !out_vld_q, "result register busy on read data")
  `PIDA_ASSERT(a_count_at_accept, clk_i, rst_ni, !in_fire |=> $stable(count_q), "count moved without a command")
  `PIDA_ASSERT(a_no_write_on_read, clk_i, rst_ni, (state_q == S_RD_REQ || state_q == S_RD_WAIT) |-> !we, "memory written during read all")

endmodule

`default_nettype wire
